// File: sv/assert_macros.svh
// Assertion macros shared by the frame builder modules.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Expression must never be true out of reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

// File: sv/crcfb_pkg.sv
// Shared types, constants and CRC step functions of the frame builder.
// No dependencies.
package crcfb_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = QAW + 1;

    localparam logic [7:0] SYNC0 = 8'hAA;
    localparam logic [7:0] SYNC1 = 8'h09;
    localparam logic [7:0] SYNC2 = 8'h03;
    localparam logic [7:0] MARK0 = 8'hD0;
    localparam logic [7:0] MARK1 = 8'h10;

    // Byte positions within a frame job
    localparam logic [3:0] P_SYNC0  = 4'd0;
    localparam logic [3:0] P_SYNC1  = 4'd1;
    localparam logic [3:0] P_SYNC2  = 4'd2;
    localparam logic [3:0] P_LEN_LO = 4'd3;
    localparam logic [3:0] P_LEN_HI = 4'd4;
    localparam logic [3:0] P_HCRC   = 4'd5;
    localparam logic [3:0] P_SEQ_LO = 4'd6;
    localparam logic [3:0] P_SEQ_HI = 4'd7;
    localparam logic [3:0] P_MARK0  = 4'd8;
    localparam logic [3:0] P_MARK1  = 4'd9;
    localparam logic [3:0] P_TARGET = 4'd10;
    localparam logic [3:0] P_OPCODE = 4'd11;
    localparam logic [3:0] P_CRC_LO = 4'd12;
    localparam logic [3:0] P_CRC_HI = 4'd13;

    typedef enum logic {
        CMD_BEGIN   = 1'b0,
        CMD_PAYLOAD = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        K_BEGIN,
        K_DATA,
        K_DATA_LAST,
        K_REFUSE
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] len;
        logic [15:0] seq;
        logic [7:0]  target;
        logic [7:0]  opcode;
        logic [7:0]  data;
    } t_job;

    // CRC-8/MAXIM, reflected poly 0x8C
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
        end
        return c;
    endfunction

    // CRC-16/XMODEM, poly 0x1021 msb first
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        end
        return c;
    endfunction

endpackage

// File: sv/crcfb_front.sv
// Front end: accepts items, tracks frame state and sequence number,
// classifies each item into a job. Depends on crcfb_pkg.
`include "assert_macros.svh"
module crcfb_front
    import crcfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_full,
    input  logic        i_command,
    input  logic [7:0]  i_target_id,
    input  logic [7:0]  i_opcode,
    input  logic [15:0] i_payload_length,
    input  logic [7:0]  i_data_byte,
    output logic        o_push,
    output t_job        o_job
);

    logic        r_frame_open;
    logic [15:0] r_remaining;
    logic [15:0] r_seq;
    logic        n_frame_open;
    logic [15:0] n_remaining;
    logic [15:0] n_seq;
    logic        accept;

    assign accept = i_valid && !i_full;
    assign o_push = accept;

    always_comb begin
        n_frame_open = r_frame_open;
        n_remaining  = r_remaining;
        n_seq        = r_seq;
        o_job.len    = i_payload_length;
        o_job.seq    = r_seq;
        o_job.target = i_target_id;
        o_job.opcode = i_opcode;
        o_job.data   = i_data_byte;
        o_job.kind   = K_REFUSE;
        if (t_cmd'(i_command) == CMD_BEGIN) begin
            if (!r_frame_open) begin
                o_job.kind = K_BEGIN;
                if (accept) begin
                    n_seq        = 16'(r_seq + 16'd1);
                    n_frame_open = (i_payload_length != 16'd0);
                    n_remaining  = i_payload_length;
                end
            end
        end else if (r_frame_open) begin
            o_job.kind = (r_remaining == 16'd1) ? K_DATA_LAST : K_DATA;
            if (accept) begin
                n_remaining  = 16'(r_remaining - 16'd1);
                n_frame_open = (r_remaining != 16'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
            r_remaining  <= 16'd0;
            r_seq        <= 16'd0;
        end else begin
            r_frame_open <= n_frame_open;
            r_remaining  <= n_remaining;
            r_seq        <= n_seq;
        end
    end

    `ASSERT_ALWAYS(a_open_has_bytes, r_frame_open |-> (r_remaining != 16'd0), "open frame with no bytes left")

endmodule

// File: sv/crcfb_queue.sv
// Short job queue between front and back end.
// Depends on crcfb_pkg.
`include "assert_macros.svh"
module crcfb_queue
    import crcfb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QCW-1:0] r_count;

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= QAW'(r_wr + 1'b1);
            end
            if (i_pop) begin
                r_rd <= QAW'(r_rd + 1'b1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= QCW'(r_count + 1'b1);
                2'b01:   r_count <= QCW'(r_count - 1'b1);
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_push && o_full, "push into full queue")
    `ASSERT_NEVER(a_no_underflow, i_pop && !o_valid, "pop from empty queue")

endmodule

// File: sv/crcfb_back.sv
// Back end: expands jobs into frame bytes, keeps header and frame CRCs,
// drives the registered output. Depends on crcfb_pkg.
`include "assert_macros.svh"
module crcfb_back
    import crcfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    input  logic       i_stall,
    output logic       o_pop,
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_frame,
    output logic       o_error
);

    logic [3:0]  r_idx;
    logic [7:0]  r_crc8;
    logic [15:0] r_crc16;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        r_out_error;

    logic [3:0]  n_idx;
    logic [7:0]  n_crc8;
    logic [15:0] n_crc16;
    logic [7:0]  hdr_byte;
    logic [7:0]  emit_byte;
    logic        go;
    logic        done;
    logic        refuse;
    logic        is_begin;
    logic        is_crc;

    assign go       = i_job_valid && (!r_out_valid || !i_stall);
    assign refuse   = (i_job.kind == K_REFUSE);
    assign is_begin = (i_job.kind == K_BEGIN);
    assign is_crc   = (r_idx == P_CRC_LO) || (r_idx == P_CRC_HI);

    always_comb begin
        case (r_idx)
            P_SYNC0:  hdr_byte = SYNC0;
            P_SYNC1:  hdr_byte = SYNC1;
            P_SYNC2:  hdr_byte = SYNC2;
            P_LEN_LO: hdr_byte = i_job.len[7:0];
            P_LEN_HI: hdr_byte = i_job.len[15:8];
            P_HCRC:   hdr_byte = r_crc8;
            P_SEQ_LO: hdr_byte = i_job.seq[7:0];
            P_SEQ_HI: hdr_byte = i_job.seq[15:8];
            P_MARK0:  hdr_byte = MARK0;
            P_MARK1:  hdr_byte = MARK1;
            P_TARGET: hdr_byte = i_job.target;
            P_OPCODE: hdr_byte = i_job.opcode;
            P_CRC_LO: hdr_byte = r_crc16[7:0];
            P_CRC_HI: hdr_byte = r_crc16[15:8];
            default:  hdr_byte = 8'h00;
        endcase
    end

    always_comb begin
        if (refuse) begin
            emit_byte = 8'h00;
        end else if (!is_begin && r_idx == P_SYNC0) begin
            emit_byte = i_job.data;
        end else begin
            emit_byte = hdr_byte;
        end
    end

    always_comb begin
        done = refuse
            || (i_job.kind == K_DATA && r_idx == P_SYNC0)
            || (is_begin && r_idx == P_OPCODE && i_job.len != 16'd0)
            || (r_idx == P_CRC_HI);
        n_idx   = r_idx;
        n_crc8  = r_crc8;
        n_crc16 = r_crc16;
        if (go) begin
            if (done) begin
                n_idx = P_SYNC0;
            end else if (!is_begin && r_idx == P_SYNC0) begin
                n_idx = P_CRC_LO;
            end else begin
                n_idx = 4'(r_idx + 4'd1);
            end
            if (is_begin && r_idx <= P_LEN_HI) begin
                n_crc8 = crc8_step((r_idx == P_SYNC0) ? 8'h00 : r_crc8, emit_byte);
            end
            if (r_idx == P_CRC_HI) begin
                n_crc16 = 16'h0000;
            end else if (!refuse && !is_crc) begin
                n_crc16 = crc16_step((is_begin && r_idx == P_SYNC0) ? 16'h0000 : r_crc16,
                                     emit_byte);
            end
        end
    end

    assign o_pop = go && done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= P_SYNC0;
            r_crc8      <= 8'h00;
            r_crc16     <= 16'h0000;
            r_out_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_crc8  <= n_crc8;
            r_crc16 <= n_crc16;
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out_byte  <= emit_byte;
            r_out_last  <= refuse || (r_idx == P_CRC_HI);
            r_out_error <= refuse;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_last_of_frame = r_out_last;
    assign o_error         = r_out_error;

    `ASSERT_ALWAYS(a_err_is_last, (r_out_valid && r_out_error) |-> (r_out_last && r_out_byte == 8'h00), "refusal not flagged last with zero byte")
    `ASSERT_NEVER(a_idx_range, r_idx > P_CRC_HI, "byte position out of range")

endmodule

// File: sv/crc_frame_builder.sv
// Top level of the serial frame encoder: front end, job queue, back end.
// Depends on crcfb_pkg, crcfb_front, crcfb_queue, crcfb_back.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  input    | in        | i_valid / o_stall  | command, target_id, opcode, length, data
//  output   | out       | o_valid / i_stall  | out_byte, last_of_frame, error
//
// Output runs at one byte per cycle while a job is queued and i_stall is low; a payload or
// refused item yields one byte, a final payload byte three, a begin twelve (fourteen for an empty frame).
// Input takes one item per cycle while the four-entry job queue has room.
// o_stall is high only when the job queue is full; i_stall holds the output register
// and the back end. Synchronous active-low reset; no clearing pass.
module crc_frame_builder
    import crcfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [7:0]  i_target_id,
    input  logic [7:0]  i_opcode,
    input  logic [15:0] i_payload_length,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_frame,
    output logic        o_error
);

    logic push;
    logic pop;
    logic full;
    logic job_valid;
    t_job push_job;
    t_job head_job;

    assign o_stall = full;

    crcfb_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_full           (full),
        .i_command        (i_command),
        .i_target_id      (i_target_id),
        .i_opcode         (i_opcode),
        .i_payload_length (i_payload_length),
        .i_data_byte      (i_data_byte),
        .o_push           (push),
        .o_job            (push_job)
    );

    crcfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (job_valid),
        .o_job   (head_job)
    );

    crcfb_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (job_valid),
        .i_job           (head_job),
        .i_stall         (i_stall),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .o_out_byte      (o_out_byte),
        .o_last_of_frame (o_last_of_frame),
        .o_error         (o_error)
    );

endmodule

// File: tb/crc_frame_checker.sv
// Scoreboard for the frame builder: watches both channels, predicts every output transfer.
// Depends on crcfb_pkg; instantiated beside the block by tb_top.
module crc_frame_checker
    import crcfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_command,
    input  logic [7:0]  i_target_id,
    input  logic [7:0]  i_opcode,
    input  logic [15:0] i_payload_length,
    input  logic [7:0]  i_data_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_out_byte,
    input  logic        i_out_last,
    input  logic        i_out_error,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] octet;
        logic       last;
        logic       err;
    } t_frame_octet;

    t_frame_octet expected_octets[$];

    logic [15:0] seq_next;
    logic [15:0] crc_run;
    logic [15:0] left_count;
    logic        in_frame;
    int          fails = 0;

    function automatic logic [7:0] maxim8(input logic [7:0] acc, input logic [7:0] d);
        logic [7:0] r;
        r = acc ^ d;
        repeat (8) r = {1'b0, r[7:1]} ^ (r[0] ? 8'h8C : 8'h00);
        return r;
    endfunction

    function automatic logic [15:0] xmodem16(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] r;
        r = acc ^ {d, 8'h00};
        repeat (8) r = {r[14:0], 1'b0} ^ (r[15] ? 16'h1021 : 16'h0000);
        return r;
    endfunction

    task automatic push_octet(input logic [7:0] o, input logic l, input logic e);
        t_frame_octet f;
        f.octet = o;
        f.last  = l;
        f.err   = e;
        expected_octets.push_back(f);
    endtask

    task automatic frame_octet(input logic [7:0] o);
        crc_run = xmodem16(crc_run, o);
        push_octet(o, 1'b0, 1'b0);
    endtask

    task automatic close_frame();
        push_octet(crc_run[7:0], 1'b0, 1'b0);
        push_octet(crc_run[15:8], 1'b1, 1'b0);
        in_frame   = 1'b0;
        left_count = '0;
        crc_run    = '0;
    endtask

    task automatic predict_transfer(input t_cmd cmd, input logic [7:0] tgt,
                                    input logic [7:0] opc, input logic [15:0] len,
                                    input logic [7:0] dat);
        logic [7:0] hdr [5];
        logic [7:0] hdr_crc;
        if (cmd == CMD_BEGIN) begin
            if (in_frame) begin
                push_octet(8'h00, 1'b1, 1'b1);
            end else begin
                crc_run = '0;
                hdr_crc = '0;
                hdr = '{SYNC0, SYNC1, SYNC2, len[7:0], len[15:8]};
                for (int i = 0; i < 5; i++) begin
                    hdr_crc = maxim8(hdr_crc, hdr[i]);
                    frame_octet(hdr[i]);
                end
                frame_octet(hdr_crc);
                frame_octet(seq_next[7:0]);
                frame_octet(seq_next[15:8]);
                frame_octet(MARK0);
                frame_octet(MARK1);
                frame_octet(tgt);
                frame_octet(opc);
                seq_next = seq_next + 16'd1;
                if (len == '0) begin
                    close_frame();
                end else begin
                    in_frame   = 1'b1;
                    left_count = len;
                end
            end
        end else if (!in_frame) begin
            push_octet(8'h00, 1'b1, 1'b1);
        end else begin
            frame_octet(dat);
            left_count = left_count - 16'd1;
            if (left_count == '0) begin
                close_frame();
            end
        end
    endtask

    task automatic check_output();
        t_frame_octet exp_o;
        if (expected_octets.size() == 0) begin
            $error("unexpected output transfer: out_byte %02h last %0b error %0b",
                   i_out_byte, i_out_last, i_out_error);
            fails++;
        end else begin
            exp_o = expected_octets.pop_front();
            if (i_out_byte !== exp_o.octet) begin
                $error("out_byte: expected %02h, got %02h", exp_o.octet, i_out_byte);
                fails++;
            end
            if (i_out_last !== exp_o.last) begin
                $error("last_of_frame: expected %0b, got %0b", exp_o.last, i_out_last);
                fails++;
            end
            if (i_out_error !== exp_o.err) begin
                $error("error: expected %0b, got %0b", exp_o.err, i_out_error);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seq_next   = '0;
            crc_run    = '0;
            left_count = '0;
            in_frame   = 1'b0;
            expected_octets.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                predict_transfer(t_cmd'(i_command), i_target_id, i_opcode,
                                 i_payload_length, i_data_byte);
            end
            if (i_out_valid && !i_out_stall) begin
                check_output();
            end
        end
        o_pending    <= expected_octets.size();
        o_fail_count <= fails;
    end

endmodule

// File: tb/tb_top.sv
// Testbench top for crc_frame_builder: clock, reset, stimulus, receiver and verdict.
// Depends on crcfb_pkg, crc_frame_builder and crc_frame_checker.
module tb_top;
    import crcfb_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int WD_LIMIT    = 5000;
    localparam int DRAIN       = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_command = 1'b0;
    logic [7:0]  i_target_id = '0;
    logic [7:0]  i_opcode = '0;
    logic [15:0] i_payload_length = '0;
    logic [7:0]  i_data_byte = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last_of_frame;
    logic        o_error;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    crc_frame_builder DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_command        (i_command),
        .i_target_id      (i_target_id),
        .i_opcode         (i_opcode),
        .i_payload_length (i_payload_length),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_byte       (o_out_byte),
        .o_last_of_frame  (o_last_of_frame),
        .o_error          (o_error)
    );

    crc_frame_checker u_frame_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_command        (i_command),
        .i_target_id      (i_target_id),
        .i_opcode         (i_opcode),
        .i_payload_length (i_payload_length),
        .i_data_byte      (i_data_byte),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_out_byte       (o_out_byte),
        .i_out_last       (o_last_of_frame),
        .i_out_error      (o_error),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_item(input t_cmd cmd, input logic [7:0] tgt, input logic [7:0] opc,
                             input logic [15:0] len, input logic [7:0] dat);
        int gap;
        i_valid          <= 1'b1;
        i_command        <= cmd;
        i_target_id      <= tgt;
        i_opcode         <= opc;
        i_payload_length <= len;
        i_data_byte      <= dat;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // receiver: random stall stretches, one long hold-off on request
    initial begin
        int r;
        int n;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                n = HOLD_CYCLES;
            end else if (quiet) begin
                i_stall <= 1'b0;
                n = 1;
            end else begin
                r = $urandom_range(0, 9);
                if (r < 5) begin
                    i_stall <= 1'b0;
                    n = $urandom_range(1, 8);
                end else if (r == 5) begin
                    i_stall <= 1'b0;
                    n = $urandom_range(20, 60);
                end else begin
                    i_stall <= 1'b1;
                    n = pick_gap();
                    if (n == 0) n = 1;
                end
            end
            repeat (n) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WD_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int n_items;
        int len;
        bit held;
        n_items = 0;
        held    = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: refusals, empty frames, extremes of the fields
        send_item(CMD_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'hFF);
        send_item(CMD_BEGIN, 8'h00, 8'h00, 16'h0000, 8'h00);
        send_item(CMD_BEGIN, 8'hFF, 8'hFF, 16'h0000, 8'hFF);
        send_item(CMD_BEGIN, 8'h12, 8'h34, 16'h0001, 8'h00);
        send_item(CMD_BEGIN, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
        send_item(CMD_PAYLOAD, 8'hFF, 8'hFF, 16'hFFFF, 8'h00);
        send_item(CMD_BEGIN, 8'hA5, 8'h5A, 16'h0003, 8'h11);
        send_item(CMD_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h80);
        send_item(CMD_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h7F);
        send_item(CMD_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'hFF);
        send_item(CMD_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h55);
        send_item(CMD_BEGIN, 8'h01, 8'h80, 16'h0002, 8'h00);
        send_item(CMD_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h01);
        send_item(CMD_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'hFE);

        // random: mostly well-formed frames, some stray payloads and begins mid-frame
        while (n_items < 90) begin
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0) begin
                send_item(CMD_PAYLOAD, 8'($urandom), 8'($urandom), 16'($urandom),
                          8'($urandom));
                n_items++;
            end else begin
                if (!held && n_items >= 40) begin
                    quiet    = 1'b0;
                    hold_req = 1'b1;
                    held     = 1'b1;
                end
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40)
                                                  : $urandom_range(0, 6);
                send_item(CMD_BEGIN, 8'($urandom), 8'($urandom), 16'(len), 8'($urandom));
                n_items++;
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 11) == 0) begin
                        send_item(CMD_BEGIN, 8'($urandom), 8'($urandom), 16'($urandom),
                                  8'($urandom));
                        n_items++;
                    end
                    send_item(CMD_PAYLOAD, 8'($urandom), 8'($urandom), 16'($urandom),
                              8'($urandom));
                    n_items++;
                end
            end
        end

        // largest length opens a frame; a few bytes of it and a refused begin
        quiet = 1'b1;
        send_item(CMD_BEGIN, 8'($urandom), 8'($urandom), 16'hFFFF, 8'($urandom));
        for (int i = 0; i < 3; i++) begin
            send_item(CMD_PAYLOAD, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
        end
        send_item(CMD_BEGIN, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/crcfb_pkg.sv
sv/crcfb_front.sv
sv/crcfb_queue.sv
sv/crcfb_back.sv
sv/crc_frame_builder.sv
tb/crc_frame_checker.sv
tb/tb_top.sv
